// ===== hw/rtl/lcpf_pkg.sv =====
// package: constants, widths and types for the led controller packet framer
`default_nettype none
package lcpf_pkg;

    localparam int MAX_PAYLOAD   = 1472;
    localparam int LEDS_PER_PORT = 684;
    localparam int PORT_COUNT    = 8;

    localparam int FRAME_BYTES   = LEDS_PER_PORT * PORT_COUNT;
    localparam int HDR_BYTES     = 10;
    localparam int SEC_HDR_BYTES = 4;
    localparam int MIN_SECTION   = 5;
    localparam int ALIGN_BITS    = 11;
    localparam int ZERO_BYTES    = 8;

    localparam int LEN_W = $clog2(((MAX_PAYLOAD > LEDS_PER_PORT) ? MAX_PAYLOAD
                                                                  : LEDS_PER_PORT) + 1);
    localparam int FB_W  = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W = 5;
    localparam int OFF_W = 16;

    localparam logic [IDX_W-1:0] IDX_ZERO   = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_HDR    = IDX_W'(ZERO_BYTES);
    localparam logic [IDX_W-1:0] IDX_SECT   = IDX_W'(ZERO_BYTES + HDR_BYTES);
    localparam logic [IDX_W-1:0] IDX_DATA   = IDX_W'(ZERO_BYTES + HDR_BYTES + SEC_HDR_BYTES);

    localparam logic [7:0] BYTE_Y    = 8'h59;
    localparam logic [7:0] BYTE_T    = 8'h54;
    localparam logic [7:0] BYTE_K    = 8'h4B;
    localparam logic [7:0] BYTE_J    = 8'h4A;
    localparam logic [7:0] BYTE_PROT = 8'h57;
    localparam logic [7:0] BYTE_VER  = 8'h05;

    // register index, taken from the word address bits of paddr
    localparam int                   REG_IDX_W         = 1;
    localparam logic [REG_IDX_W-1:0] REG_CONTROLLER_ID = REG_IDX_W'(0);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PLAN = 4'b0010,
        S_SECT = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/led_controller_packet_framer.sv =====
// led controller packet framer: led bytes in, datagram bytes out
// order: an item inside an open section goes straight to S_EMIT, one that opens a section
//   passes S_SECT first, and one that opens a packet passes S_PLAN and then S_SECT; then
//   1 to 23 results, one per cycle while out_stall is low
// throughput: one item at a time; in_stall stays high until its last result is taken
// reset: asynchronous active low; controller_id returns to 1, frame state clears
`default_nettype none
module led_controller_packet_framer
    import lcpf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  led_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             datagram_last,
    output logic             item_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    state_t             state_reg, state_next;
    logic [7:0]         cid_reg;
    logic [FB_W-1:0]    done_reg;
    logic [LEN_W-1:0]   pp_reg;
    logic [LEN_W-1:0]   sdl_reg;
    logic [LEN_W-1:0]   carry_reg;
    logic [OFF_W-1:0]   off_reg;
    logic               first_reg;

    logic [7:0]         data_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   take_reg;
    logic [OFF_W-1:0]   sec_off_reg;

    logic [LEN_W-1:0]   ppos_reg;
    logic [LEN_W-1:0]   pcarry_reg;
    logic [FB_W-1:0]    prem_reg;
    logic [7:0]         pcnt_reg;

    logic               in_acc, out_acc, cfg_wr;
    logic               id_sel;
    logic               need_packet;
    logic               plan_go;
    logic [LEN_W-1:0]   p_need, p_room, p_take;
    logic [LEN_W:0]     p_pos_min;
    logic [LEN_W-1:0]   s_need, s_room;
    logic [FB_W-1:0]    done_inc;
    logic               frame_end;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign id_sel  = (paddr[2 +: REG_IDX_W] == REG_CONTROLLER_ID);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign pready    = 1'b1;
    assign prdata    = id_sel ? {24'd0, cid_reg} : 32'd0;

    assign need_packet = (pp_reg == '0) ||
                         ({1'b0, pp_reg} + (LEN_W+1)'(MIN_SECTION) > (LEN_W+1)'(MAX_PAYLOAD));

    // plan unit: one section per cycle in S_PLAN
    assign p_pos_min = {1'b0, ppos_reg} + (LEN_W+1)'(MIN_SECTION);
    assign plan_go   = (prem_reg != '0) && (p_pos_min <= (LEN_W+1)'(MAX_PAYLOAD));
    assign p_need    = (pcarry_reg != '0) ? pcarry_reg : LEN_W'(LEDS_PER_PORT);
    assign p_room    = LEN_W'(MAX_PAYLOAD) - ppos_reg - LEN_W'(SEC_HDR_BYTES);
    assign p_take    = (p_need > p_room) ? p_room : p_need;

    assign s_need = (carry_reg != '0) ? carry_reg : LEN_W'(LEDS_PER_PORT);
    assign s_room = LEN_W'(MAX_PAYLOAD) - pp_reg - LEN_W'(SEC_HDR_BYTES);

    assign done_inc  = done_reg + FB_W'(1);
    assign frame_end = (done_inc >= FB_W'(FRAME_BYTES));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (sdl_reg != '0)
                        state_next = S_EMIT;
                    else if (need_packet)
                        state_next = S_PLAN;
                    else
                        state_next = S_SECT;
                end
            end
            S_PLAN:
            begin
                if (!plan_go)
                    state_next = S_SECT;
            end
            S_SECT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_acc && idx_reg == IDX_DATA)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (idx_reg)
            IDX_HDR:                out_byte = BYTE_Y;
            IDX_HDR + IDX_W'(1):    out_byte = BYTE_T;
            IDX_HDR + IDX_W'(2):    out_byte = BYTE_K;
            IDX_HDR + IDX_W'(3):    out_byte = BYTE_J;
            IDX_HDR + IDX_W'(4):    out_byte = cid_reg;
            IDX_HDR + IDX_W'(6):    out_byte = BYTE_PROT;
            IDX_HDR + IDX_W'(7):    out_byte = BYTE_VER;
            IDX_HDR + IDX_W'(8):    out_byte = pcnt_reg;
            IDX_SECT:               out_byte = sec_off_reg[7:0];
            IDX_SECT + IDX_W'(1):   out_byte = sec_off_reg[15:8];
            IDX_SECT + IDX_W'(2):   out_byte = take_reg[7:0];
            IDX_SECT + IDX_W'(3):   out_byte = 8'(take_reg >> 8);
            IDX_DATA:               out_byte = data_reg;
            default:                out_byte = 8'd0;
        endcase
    end

    assign item_last     = (idx_reg == IDX_DATA);
    assign datagram_last = item_last && frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cid_reg   <= 8'd1;
            done_reg  <= '0;
            pp_reg    <= '0;
            sdl_reg   <= '0;
            carry_reg <= '0;
            off_reg   <= '0;
            first_reg <= 1'b1;
            idx_reg   <= IDX_DATA;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && id_sel)
                cid_reg <= pwdata[7:0];
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (sdl_reg != '0)
                            idx_reg <= IDX_DATA;
                        else if (need_packet)
                        begin
                            idx_reg   <= first_reg ? IDX_HDR : IDX_ZERO;
                            first_reg <= 1'b0;
                            pp_reg    <= LEN_W'(HDR_BYTES);
                        end
                        else
                            idx_reg <= IDX_SECT;
                    end
                end
                S_PLAN:
                begin
                end
                S_SECT:
                begin
                    if (s_need > s_room)
                    begin
                        carry_reg <= s_need - s_room;
                        off_reg   <= off_reg + OFF_W'(s_room);
                        sdl_reg   <= s_room;
                    end
                    else
                    begin
                        carry_reg <= '0;
                        off_reg   <= {off_reg[OFF_W-1:ALIGN_BITS] + (OFF_W-ALIGN_BITS)'(1),
                                      ALIGN_BITS'(0)};
                        sdl_reg   <= s_need;
                    end
                    pp_reg <= pp_reg + LEN_W'(SEC_HDR_BYTES);
                end
                S_EMIT:
                begin
                    if (out_acc)
                    begin
                        if (idx_reg == IDX_DATA)
                        begin
                            if (frame_end)
                            begin
                                done_reg  <= '0;
                                pp_reg    <= '0;
                                sdl_reg   <= '0;
                                carry_reg <= '0;
                                off_reg   <= '0;
                                first_reg <= 1'b1;
                            end
                            else
                            begin
                                done_reg <= done_inc;
                                pp_reg   <= pp_reg + LEN_W'(1);
                                if (sdl_reg != '0)
                                    sdl_reg <= sdl_reg - LEN_W'(1);
                            end
                        end
                        else
                            idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload, plan and section header registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            data_reg   <= led_byte;
            ppos_reg   <= LEN_W'(HDR_BYTES);
            pcarry_reg <= carry_reg;
            prem_reg   <= FB_W'(FRAME_BYTES) - done_reg;
            pcnt_reg   <= 8'd0;
        end
        else if (state_reg == S_PLAN && plan_go)
        begin
            pcnt_reg   <= pcnt_reg + 8'd1;
            ppos_reg   <= ppos_reg + LEN_W'(SEC_HDR_BYTES) + p_take;
            prem_reg   <= (FB_W'(p_take) >= prem_reg) ? '0 : prem_reg - FB_W'(p_take);
            pcarry_reg <= (p_need > p_take) ? p_need - p_take : '0;
        end
        if (state_reg == S_SECT)
        begin
            sec_off_reg <= off_reg;
            take_reg    <= (s_need > s_room) ? s_room : s_need;
        end
    end

`ifndef SYNTHESIS
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input not stalled while an item is in progress");

    a_pp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pp_reg <= LEN_W'(MAX_PAYLOAD))
        else $error("packet position beyond payload limit");

    a_sect_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SECT) |->
        ({1'b0, pp_reg} + (LEN_W+1)'(MIN_SECTION) <= (LEN_W+1)'(MAX_PAYLOAD)))
        else $error("section opened without room for a data byte");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && datagram_last) |=> (done_reg == '0 && first_reg && pp_reg == '0))
        else $error("frame state not restarted after final byte");

    a_emit_has_section: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && idx_reg == IDX_DATA) |-> (sdl_reg != '0))
        else $error("data byte emitted with no open section");
`endif

endmodule
`default_nettype wire

// ===== test/led_controller_packet_framer_tb.sv =====
// testbench for the led controller packet framer: predicts every datagram byte and checks it
module led_controller_packet_framer_tb;
    import lcpf_pkg::*;

    localparam int          REG_SPARE    = 1;
    localparam logic [2:0]  ADDR_CTRL_ID = 3'(4 * REG_CONTROLLER_ID);
    localparam logic [2:0]  ADDR_SPARE   = 3'(4 * REG_SPARE);
    localparam int          STUCK_LIMIT  = 2000;
    localparam int          TAIL_CYCLES  = 60;

    typedef struct packed {
        logic [7:0] data;
        logic       dlast;
        logic       ilast;
    } dgram_byte_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  led_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        datagram_last;
    logic        item_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // framer state as predicted
    logic [7:0]  ctrl_id;
    int          led_bytes_taken;
    int          pkt_pos;
    int          sec_left;
    int          split_left;
    logic [15:0] chan_off;
    bit          first_pkt;

    dgram_byte_t dgram_q[$];
    int          errors;
    int          stuck_cycles;
    bit          idle_on;
    int          burst_left;
    int          stall_mode;
    int          stall_run;

    led_controller_packet_framer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .led_byte      (led_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .datagram_last (datagram_last),
        .item_last     (item_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    task automatic restart_frame();
        led_bytes_taken = 0;
        pkt_pos         = 0;
        sec_left        = 0;
        split_left      = 0;
        chan_off        = 16'h0000;
        first_pkt       = 1'b1;
    endtask

    // section count of the packet about to open
    function automatic int count_sections();
        int pos;
        int carry;
        int rem;
        int cnt;
        int need;
        int room;
        int take;
        pos   = HDR_BYTES;
        carry = split_left;
        rem   = FRAME_BYTES - led_bytes_taken;
        cnt   = 0;
        while (rem > 0 && pos + MIN_SECTION <= MAX_PAYLOAD)
        begin
            need  = (carry != 0) ? carry : LEDS_PER_PORT;
            room  = MAX_PAYLOAD - pos - SEC_HDR_BYTES;
            take  = (need > room) ? room : need;
            cnt++;
            pos  += SEC_HDR_BYTES + take;
            rem   = (take >= rem) ? 0 : rem - take;
            carry = (need > take) ? need - take : 0;
        end
        return cnt;
    endfunction

    task automatic predict_datagram(input logic [7:0] b);
        logic [7:0] bytes_q[$];
        int         need;
        int         room;
        int         take;
        int         sections;
        bit         frame_end;
        if (sec_left == 0)
        begin
            if (pkt_pos == 0 || pkt_pos + MIN_SECTION > MAX_PAYLOAD)
            begin
                sections = count_sections();
                if (!first_pkt)
                    repeat (ZERO_BYTES) bytes_q.push_back(8'h00);
                first_pkt = 1'b0;
                bytes_q.push_back(BYTE_Y);
                bytes_q.push_back(BYTE_T);
                bytes_q.push_back(BYTE_K);
                bytes_q.push_back(BYTE_J);
                bytes_q.push_back(ctrl_id);
                bytes_q.push_back(8'h00);
                bytes_q.push_back(BYTE_PROT);
                bytes_q.push_back(BYTE_VER);
                bytes_q.push_back(8'(sections));
                bytes_q.push_back(8'h00);
                pkt_pos = HDR_BYTES;
            end
            bytes_q.push_back(chan_off[7:0]);
            bytes_q.push_back(chan_off[15:8]);
            need = (split_left != 0) ? split_left : LEDS_PER_PORT;
            room = MAX_PAYLOAD - pkt_pos - SEC_HDR_BYTES;
            if (need > room)
            begin
                take       = room;
                split_left = need - take;
                chan_off   = chan_off + 16'(take);
            end
            else
            begin
                take       = need;
                split_left = 0;
                chan_off   = 16'(((int'(chan_off) >> ALIGN_BITS) + 1) << ALIGN_BITS);
            end
            bytes_q.push_back(8'(take));
            bytes_q.push_back(8'(take >> 8));
            pkt_pos += SEC_HDR_BYTES;
            sec_left = take;
        end
        bytes_q.push_back(b);
        pkt_pos++;
        if (sec_left > 0)
            sec_left--;
        led_bytes_taken++;
        frame_end = (led_bytes_taken >= FRAME_BYTES);
        if (frame_end)
            restart_frame();
        foreach (bytes_q[i])
            dgram_q.push_back(dgram_byte_t'{bytes_q[i],
                                            frame_end && (i == bytes_q.size() - 1),
                                            i == bytes_q.size() - 1});
    endtask

    task automatic send_led(input logic [7:0] b);
        int gap;
        if (idle_on && burst_left == 0)
        begin
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            @(negedge clk);
            in_valid <= 1'b0;
            led_byte <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        led_byte <= b;
        do @(posedge clk); while (in_stall);
        predict_datagram(b);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (dgram_q.size() != 0) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_CTRL_ID)
            ctrl_id = data[7:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_ctrl_id();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_CTRL_ID;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[7:0] !== ctrl_id)
        begin
            $error("controller_id read: expected %0h actual %0h", ctrl_id, prdata[7:0]);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_register_access();
        check_ctrl_id();
        reg_write(ADDR_CTRL_ID, 32'hFFFF_FF00);
        check_ctrl_id();
        reg_write(ADDR_SPARE, 32'h0000_00AB);
        check_ctrl_id();
        reg_write(ADDR_CTRL_ID, 32'h5A5A_A5FF);
        check_ctrl_id();
    endtask

    task automatic test_directed_bytes();
        logic [7:0] pattern[$];
        pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
                    8'h0F, 8'hF0, 8'h33, 8'hCC};
        idle_on = 1'b0;
        foreach (pattern[i])
            send_led(pattern[i]);
        idle_on = 1'b1;
        repeat (8) send_led(8'($urandom));
        wait_drain();
    endtask

    // random bytes with a controller id write between two items
    task automatic test_stream_with_config();
        int count;
        count = 0;
        while (count < 100)
        begin
            if (count % 25 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (count == 50)
            begin
                wait_drain();
                reg_write(ADDR_CTRL_ID, 32'h0000_0000);
                check_ctrl_id();
            end
            send_led(8'($urandom));
            count++;
        end
        wait_drain();
    endtask

    task automatic test_drained_stream();
        reg_write(ADDR_CTRL_ID, $urandom);
        check_ctrl_id();
        idle_on = 1'b1;
        for (int i = 0; i < 110; i++)
        begin
            if (i == 55)
                wait_drain();
            send_led(8'($urandom));
        end
        wait_drain();
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(16, 200);
        end
        stall_run--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ((stall_run % 11) < 7);
        endcase
    end

    always @(posedge clk)
    begin : check_out
        dgram_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (dgram_q.size() == 0)
            begin
                $error("unexpected out_byte %0h", out_byte);
                errors++;
            end
            else
            begin
                want = dgram_q.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %0h actual %0h", want.data, out_byte);
                    errors++;
                end
                if (datagram_last !== want.dlast)
                begin
                    $error("datagram_last: expected %0b actual %0b", want.dlast, datagram_last);
                    errors++;
                end
                if (item_last !== want.ilast)
                begin
                    $error("item_last: expected %0b actual %0b", want.ilast, item_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        led_byte     = 8'h00;
        out_stall    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = 3'd0;
        pwdata       = 32'h0;
        errors       = 0;
        stuck_cycles = 0;
        idle_on      = 1'b0;
        burst_left   = 0;
        stall_mode   = 0;
        stall_run    = 0;
        ctrl_id      = 8'h01;
        restart_frame();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_directed_bytes();
        test_stream_with_config();
        test_drained_stream();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && dgram_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
